/* sv/hex_to_base64_converter_unit_assert.svh */
// Assertion helpers used by the checker.
`ifndef HEX_TO_BASE64_CONVERTER_UNIT_ASSERT_SVH
`define HEX_TO_BASE64_CONVERTER_UNIT_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define H2B64_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that the antecedent in one cycle implies the consequent in the next.
`define H2B64_ASSERT_NEXT(label, ante, cons, msg) \
    `H2B64_ASSERT(label, (ante) |=> (cons), msg)

`endif

/* sv/h2b64_pkg.sv */
package h2b64_pkg;

    localparam int JOBQ_DEPTH = 4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_HEX  = 2'd1;
    localparam logic [1:0] ST_ODD_LEN  = 2'd2;

    localparam logic [7:0] PAD_CHAR    = 8'h3D;

    typedef struct packed {
        logic [7:0] hex_char;
        logic       end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [7:0] b64_char;
        logic [1:0] status;
        logic       final_char;
    } t_out_item;

    typedef enum logic [1:0] {
        JOB_ERROR,
        JOB_FULL,
        JOB_ONE_BYTE,
        JOB_TWO_BYTES
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic [23:0] word;
        logic [1:0]  status;
        logic        last;
    } t_job;

    function automatic logic [7:0] b64_symbol(input logic [5:0] v);
        logic [7:0] ext;
        logic [7:0] ch;
        ext = {2'b00, v};
        case (v) inside
            [6'd0:6'd25]:  ch = ext + 8'h41;
            [6'd26:6'd51]: ch = ext + 8'h47;
            [6'd52:6'd61]: ch = ext - 8'd4;
            6'd62:         ch = 8'h2B;
            default:       ch = 8'h2F;
        endcase
        return ch;
    endfunction

endpackage

/* sv/hex_to_base64_converter_unit.sv */
// The digit that completes a job writes it into the job queue; the result register
// then loads the job's first character from the queue head.
// Throughput: one hex digit a cycle while the job queue has room; one result a beat.
// A job holds the back end for four characters (one for an error), so short padded
// strings can fill the queue and raise full.
// Reset: synchronous, active low; clears digit and group state, queue and result valid.
module hex_to_base64_converter_unit #(
    parameter int P_JOBQ_DEPTH = h2b64_pkg::JOBQ_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  h2b64_pkg::t_in_item  i_in_item,
    output logic                 empty,
    input  logic                 pop,
    output h2b64_pkg::t_out_item o_out_item
);
    import h2b64_pkg::*;

    logic q_full, q_empty, q_pop, job_push;
    t_job job, head;

    assign full = q_full;

    h2b64_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (push && !q_full),
        .i_item     (i_in_item),
        .o_job_push (job_push),
        .o_job      (job)
    );

    h2b64_jobq #(
        .DEPTH (P_JOBQ_DEPTH)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (head)
    );

    h2b64_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_head    (head),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_out_item)
    );

endmodule

/* sv/h2b64_front.sv */
module h2b64_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  h2b64_pkg::t_in_item i_item,
    output logic                o_job_push,
    output h2b64_pkg::t_job     o_job
);
    import h2b64_pkg::*;

    logic [3:0]  r_high_nibble, n_high_nibble;
    logic        r_nibble_pending, n_nibble_pending;
    logic [15:0] r_group_bytes, n_group_bytes;
    logic [1:0]  r_group_count, n_group_count;
    logic        r_skipping, n_skipping;

    logic [3:0]  digit;
    logic        digit_ok;
    logic [7:0]  byte_val;
    logic        last;

    assign last     = i_item.end_of_string;
    assign byte_val = {r_high_nibble, digit};

    always_comb begin
        digit    = 4'd0;
        digit_ok = 1'b1;
        case (i_item.hex_char) inside
            [8'h30:8'h39]: digit = i_item.hex_char[3:0];
            [8'h41:8'h46],
            [8'h61:8'h66]: digit = i_item.hex_char[3:0] + 4'd9;
            default:       digit_ok = 1'b0;
        endcase
    end

    always_comb begin
        n_high_nibble    = r_high_nibble;
        n_nibble_pending = r_nibble_pending;
        n_group_bytes    = r_group_bytes;
        n_group_count    = r_group_count;
        n_skipping       = r_skipping;
        o_job_push       = 1'b0;
        o_job.kind       = JOB_ERROR;
        o_job.word       = 24'd0;
        o_job.status     = ST_OK;
        o_job.last       = last;
        if (r_skipping) begin
            if (last) n_skipping = 1'b0;
        end else if (!r_nibble_pending && last) begin
            o_job_push       = 1'b1;
            o_job.status     = ST_ODD_LEN;
            n_high_nibble    = 4'd0;
            n_nibble_pending = 1'b0;
            n_group_bytes    = 16'd0;
            n_group_count    = 2'd0;
        end else if (!digit_ok) begin
            o_job_push       = 1'b1;
            o_job.status     = ST_BAD_HEX;
            n_skipping       = !last;
            n_high_nibble    = 4'd0;
            n_nibble_pending = 1'b0;
            n_group_bytes    = 16'd0;
            n_group_count    = 2'd0;
        end else if (!r_nibble_pending) begin
            n_high_nibble    = digit;
            n_nibble_pending = 1'b1;
        end else begin
            n_high_nibble    = 4'd0;
            n_nibble_pending = 1'b0;
            if (r_group_count == 2'd2) begin
                o_job_push    = 1'b1;
                o_job.kind    = JOB_FULL;
                o_job.word    = {r_group_bytes, byte_val};
                n_group_bytes = 16'd0;
                n_group_count = 2'd0;
            end else if (last) begin
                // flush a partial group with padding
                o_job_push    = 1'b1;
                if (r_group_count == 2'd0) begin
                    o_job.kind = JOB_ONE_BYTE;
                    o_job.word = {byte_val, 16'd0};
                end else begin
                    o_job.kind = JOB_TWO_BYTES;
                    o_job.word = {r_group_bytes[7:0], byte_val, 8'd0};
                end
                n_group_bytes = 16'd0;
                n_group_count = 2'd0;
            end else begin
                n_group_bytes = {r_group_bytes[7:0], byte_val};
                n_group_count = r_group_count + 2'd1;
            end
        end
        if (!i_accept) o_job_push = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_nibble    <= 4'd0;
            r_nibble_pending <= 1'b0;
            r_group_bytes    <= 16'd0;
            r_group_count    <= 2'd0;
            r_skipping       <= 1'b0;
        end else if (i_accept) begin
            r_high_nibble    <= n_high_nibble;
            r_nibble_pending <= n_nibble_pending;
            r_group_bytes    <= n_group_bytes;
            r_group_count    <= n_group_count;
            r_skipping       <= n_skipping;
        end
    end

endmodule

/* sv/h2b64_jobq.sv */
module h2b64_jobq #(
    parameter int DEPTH = h2b64_pkg::JOBQ_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  h2b64_pkg::t_job i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output h2b64_pkg::t_job o_head
);
    import h2b64_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= next_ptr(r_wr_ptr);
            if (do_pop)  r_rd_ptr <= next_ptr(r_rd_ptr);
            if (do_push && !do_pop)      r_count <= r_count + CW'(1);
            else if (do_pop && !do_push) r_count <= r_count - CW'(1);
        end
    end

endmodule

/* sv/h2b64_back.sv */
module h2b64_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  h2b64_pkg::t_job      i_head,
    output logic                 o_q_pop,
    input  logic                 i_pop,
    output logic                 o_empty,
    output h2b64_pkg::t_out_item o_result
);
    import h2b64_pkg::*;

    logic [1:0] r_idx;
    logic       r_out_valid;
    t_out_item  r_out, n_out;
    logic [5:0] sextet;
    logic       load, job_done;

    always_comb begin
        case (r_idx)
            2'd0:    sextet = i_head.word[23:18];
            2'd1:    sextet = i_head.word[17:12];
            2'd2:    sextet = i_head.word[11:6];
            default: sextet = i_head.word[5:0];
        endcase
    end

    always_comb begin
        n_out.status     = i_head.status;
        n_out.final_char = 1'b0;
        n_out.b64_char   = b64_symbol(sextet);
        case (i_head.kind)
            JOB_ERROR: begin
                n_out.b64_char   = 8'h00;
                n_out.final_char = 1'b1;
            end
            JOB_FULL: begin
                n_out.final_char = (r_idx == 2'd3) && i_head.last;
            end
            JOB_ONE_BYTE: begin
                if (r_idx[1]) n_out.b64_char = PAD_CHAR;
                n_out.final_char = (r_idx == 2'd3);
            end
            default: begin
                if (r_idx == 2'd3) n_out.b64_char = PAD_CHAR;
                n_out.final_char = (r_idx == 2'd3);
            end
        endcase
    end

    assign job_done = (i_head.kind == JOB_ERROR) || (r_idx == 2'd3);
    assign load     = !i_q_empty && (!r_out_valid || i_pop);
    assign o_q_pop  = load && job_done;
    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
        end else if (load) begin
            r_out       <= n_out;
            r_out_valid <= 1'b1;
            r_idx       <= job_done ? 2'd0 : r_idx + 2'd1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

/* sv/h2b64_checker.sv */
`include "hex_to_base64_converter_unit_assert.svh"

module h2b64_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 empty,
    input logic                 pop,
    input h2b64_pkg::t_out_item o_out_item
);
    import h2b64_pkg::*;

    logic stalled;
    logic err_ok;
    logic b64_ok;
    logic pad_open;
    logic pad_now;

    assign stalled  = !empty && !pop;
    assign err_ok   = o_out_item.final_char && (o_out_item.b64_char == 8'h00)
                      && (o_out_item.status inside {ST_BAD_HEX, ST_ODD_LEN});
    assign b64_ok   = o_out_item.b64_char inside {[8'h41:8'h5A], [8'h61:8'h7A],
                                                  [8'h30:8'h39], 8'h2B, 8'h2F, PAD_CHAR};
    assign pad_open = !empty && pop && (o_out_item.b64_char == PAD_CHAR)
                      && !o_out_item.final_char;
    assign pad_now  = !empty && (o_out_item.b64_char == PAD_CHAR);

    `H2B64_ASSERT_NEXT(a_result_holds, stalled, !empty && $stable(o_out_item), "result moved")

    `H2B64_ASSERT(a_error_shape, !empty && o_out_item.status != ST_OK |-> err_ok, "bad error")

    `H2B64_ASSERT(a_ok_symbol, !empty && o_out_item.status == ST_OK |-> b64_ok, "bad symbol")

    `H2B64_ASSERT_NEXT(a_pad_follows, pad_open, pad_now, "padding not continued")

endmodule

bind hex_to_base64_converter_unit h2b64_checker u_h2b64_checker (.*);

/* tb/hex_to_base64_converter_unit_tb.sv */
`timescale 1ns / 100ps

module hex_to_base64_converter_unit_tb;

    import h2b64_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        t_in_item item;
        int       gap;
        bit       wait_drain;
    } t_feed_entry;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    t_in_item  i_in_item = '0;
    logic      empty;
    logic      pop = 1'b0;
    t_out_item o_out_item;

    hex_to_base64_converter_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Encoder shadow state
    logic [3:0]  hi_nib;
    logic        nib_held;
    logic [15:0] grp_bytes;
    logic [1:0]  grp_cnt;
    logic        skip_rest;

    string b64_alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    string hex_digits = "0123456789abcdefABCDEF";

    t_out_item   b64_expected[$];
    t_feed_entry hex_feed_q[$];

    bit feed_calm;
    bit pop_calm;
    bit in_beat;
    bit out_beat;
    int gap_left;
    int pop_wait;
    int stall_cycles;
    int n_hex_total;
    int n_hex_taken;
    int n_strings;
    int n_results;
    int n_bad_hex;
    int n_odd_len;
    int n_errors;

    function automatic int hex_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
        return -1;
    endfunction

    function automatic void clear_group();
        hi_nib = '0;
        nib_held = 1'b0;
        grp_bytes = '0;
        grp_cnt = '0;
    endfunction

    function automatic void add_b64(input logic [7:0] ch, input logic [1:0] st,
                                    input logic fin);
        t_out_item r;
        r.b64_char = ch;
        r.status = st;
        r.final_char = fin;
        b64_expected.insert(b64_expected.size(), r);
    endfunction

    // Emit four characters, the trailing npad of them as padding.
    function automatic void add_quad(input logic [23:0] word, input int npad,
                                     input logic fin);
        logic [5:0] idx;
        for (int k = 0; k < 4; k++) begin
            idx = 6'((word >> (18 - 6 * k)) & 24'h3F);
            if (k >= 4 - npad)
                add_b64(PAD_CHAR, ST_OK, fin && k == 3);
            else
                add_b64(b64_alpha[idx], ST_OK, fin && k == 3);
        end
    endfunction

    function automatic void predict_b64(input t_in_item it);
        int         dv;
        logic [7:0] byte_v;
        if (skip_rest) begin
            if (it.end_of_string) skip_rest = 1'b0;
            return;
        end
        dv = hex_value(it.hex_char);
        if (!nib_held && it.end_of_string) begin
            clear_group();
            add_b64(8'h00, ST_ODD_LEN, 1'b1);
            return;
        end
        if (dv < 0) begin
            clear_group();
            skip_rest = !it.end_of_string;
            add_b64(8'h00, ST_BAD_HEX, 1'b1);
            return;
        end
        if (!nib_held) begin
            hi_nib = 4'(dv);
            nib_held = 1'b1;
            return;
        end
        byte_v = {hi_nib, 4'(dv)};
        nib_held = 1'b0;
        hi_nib = '0;
        if (grp_cnt >= 2) begin
            add_quad({grp_bytes, byte_v}, 0, it.end_of_string);
            clear_group();
            return;
        end
        grp_bytes = {grp_bytes[7:0], byte_v};
        grp_cnt = grp_cnt + 2'd1;
        if (!it.end_of_string) return;
        if (grp_cnt == 2'd1)
            add_quad({grp_bytes[7:0], 16'h0000}, 2, 1'b1);
        else
            add_quad({grp_bytes, 8'h00}, 1, 1'b1);
        clear_group();
    endfunction

    task automatic feed_char(input logic [7:0] c, input logic last);
        t_feed_entry e;
        e.item.hex_char = c;
        e.item.end_of_string = last;
        e.gap = feed_calm ? 0 : $urandom_range(0, 5);
        e.wait_drain = 1'b0;
        hex_feed_q.insert(hex_feed_q.size(), e);
        n_hex_total++;
        if (last) n_strings++;
    endtask

    task automatic feed_str(input string s);
        for (int i = 0; i < s.len(); i++)
            feed_char(s[i], i == s.len() - 1);
    endtask

    task automatic feed_drain();
        t_feed_entry e;
        e.item = '0;
        e.gap = 0;
        e.wait_drain = 1'b1;
        hex_feed_q.insert(hex_feed_q.size(), e);
    endtask

    function automatic logic [7:0] any_hex_digit();
        return hex_digits[$urandom_range(0, hex_digits.len() - 1)];
    endfunction

    // Drive one beat at a time; hold until taken, then idle for the drawn gap.
    always @(negedge i_clk) begin : feed_drv
        logic     nxt_push;
        t_in_item nxt_item;
        nxt_push = push;
        nxt_item = i_in_item;
        if (i_rst_n && !(push && !in_beat)) begin
            nxt_push = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (hex_feed_q.size() > 0) begin
                if (hex_feed_q[0].wait_drain) begin
                    if (b64_expected.size() == 0) void'(hex_feed_q.pop_front());
                end else begin
                    nxt_item = hex_feed_q[0].item;
                    nxt_push = 1'b1;
                    gap_left = hex_feed_q[0].gap;
                    void'(hex_feed_q.pop_front());
                end
            end
        end
        push <= nxt_push;
        i_in_item <= nxt_item;
    end

    // Raise pop after a drawn wait; keep it high until a beat goes through.
    always @(negedge i_clk) begin : pop_drv
        logic nxt_pop;
        nxt_pop = 1'b0;
        if (i_rst_n) begin
            if (out_beat) begin
                if (n_results % 40 == 0) pop_calm = ($urandom_range(0, 2) == 0);
                pop_wait = pop_calm ? 0 : $urandom_range(0, 5);
            end
            if (pop_wait > 0) pop_wait--;
            else nxt_pop = 1'b1;
        end
        pop <= nxt_pop;
    end

    always @(posedge i_clk) begin : beat_mon
        t_out_item want;
        in_beat = 1'b0;
        out_beat = 1'b0;
        if (i_rst_n) begin
            in_beat = push && !full;
            out_beat = pop && !empty;
            // Compare before predicting so a stray result cannot match a new one.
            if (out_beat) begin
                n_results++;
                if (o_out_item.status == ST_BAD_HEX) n_bad_hex++;
                if (o_out_item.status == ST_ODD_LEN) n_odd_len++;
                if (b64_expected.size() == 0) begin
                    $error("result beat with nothing expected: b64_char %h status %0d final_char %b",
                           o_out_item.b64_char, o_out_item.status, o_out_item.final_char);
                    n_errors++;
                end else begin
                    want = b64_expected.pop_front();
                    if (o_out_item.b64_char !== want.b64_char) begin
                        $error("b64_char: expected %h, got %h", want.b64_char,
                               o_out_item.b64_char);
                        n_errors++;
                    end
                    if (o_out_item.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status,
                               o_out_item.status);
                        n_errors++;
                    end
                    if (o_out_item.final_char !== want.final_char) begin
                        $error("final_char: expected %b, got %b", want.final_char,
                               o_out_item.final_char);
                        n_errors++;
                    end
                end
            end
            if (in_beat) begin
                predict_b64(i_in_item);
                n_hex_taken++;
            end
            if (in_beat || out_beat) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("hex_to_base64_converter_unit_tb failed");
                    $finish;
                end
            end
        end
    end

    initial begin : stim
        int kind;
        int len;
        int bad_pos;
        int next_drain;
        logic [7:0] c;

        clear_group();
        skip_rest = 1'b0;
        feed_calm = 1'b0;
        pop_calm = 1'b0;

        // Full groups, padded tails, odd lengths and bad digits.
        feed_str("4d616E");
        feed_str("00");
        feed_str("ffFF");
        feed_char("g", 1'b1);
        feed_char("a", 1'b0);
        feed_char("z", 1'b0);
        feed_char("1", 1'b0);
        feed_char("2", 1'b1);
        feed_char(8'h00, 1'b0);
        feed_char(8'hFF, 1'b1);
        feed_char("1", 1'b0);
        feed_char(":", 1'b1);
        feed_str("abc");
        feed_drain();

        next_drain = n_hex_total + 120;
        while (n_hex_total < 410) begin
            feed_calm = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            if ($urandom_range(0, 7) == 0) len = 2 * $urandom_range(10, 24);
            else len = 2 * $urandom_range(1, 6);
            if (kind == 7) begin
                // raw noise bytes
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    feed_char(8'($urandom_range(0, 255)), i == len - 1);
            end else begin
                if (kind == 8) len--;
                bad_pos = $urandom_range(0, len - 1);
                for (int i = 0; i < len; i++) begin
                    c = any_hex_digit();
                    if (kind == 9 && i == bad_pos) c = 8'($urandom_range(0, 255));
                    feed_char(c, i == len - 1);
                end
            end
            if (n_hex_total >= next_drain) begin
                feed_drain();
                next_drain = n_hex_total + 120;
            end
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_hex_taken < n_hex_total || b64_expected.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Encoded %0d hex strings (%0d digits) into %0d result beats,",
                 n_strings, n_hex_taken, n_results);
        $display("including %0d bad-digit and %0d odd-length terminations.",
                 n_bad_hex, n_odd_len);
        if (n_errors == 0)
            $display("hex_to_base64_converter_unit_tb passed");
        else
            $display("hex_to_base64_converter_unit_tb failed");
        $finish;
    end

endmodule
